/* rtl/wrmd_pkg.sv */
package wrmd_pkg;

  localparam int READ_W     = 24;
  localparam int THR_W      = 24;
  localparam int WLEN_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam int DEPTH_DEF  = 16;

  localparam logic signed [READ_W-1:0] RING_RESET = -24'sd1000000;
  localparam logic signed [READ_W-1:0] READ_MIN   = 24'sh800000;
  localparam logic signed [READ_W-1:0] READ_MAX   = 24'sh7FFFFF;
  localparam logic [WLEN_W-1:0]        WLEN_RESET = 5'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

  // Running extremes token handed from cell to cell.
  typedef struct packed {
    logic                     vld;
    logic signed [READ_W-1:0] hi;
    logic signed [READ_W-1:0] lo;
  } scan_t;

endpackage

/* rtl/wrmd_cell.sv */
module wrmd_cell (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       wr_en,
  input  logic signed [wrmd_pkg::READ_W-1:0]         wr_data,
  input  logic                                       in_window,
  input  wrmd_pkg::scan_t                            scan_in,
  output wrmd_pkg::scan_t                            scan_out
);
  import wrmd_pkg::*;

  logic signed [READ_W-1:0] slot_r;
  logic                     vld_r;
  logic signed [READ_W-1:0] hi_r, hi_nxt;
  logic signed [READ_W-1:0] lo_r, lo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= RING_RESET;
    end else if (wr_en) begin
      slot_r <= wr_data;
    end
  end

  // Merge own slot only when it lies inside the active window.
  always_comb begin
    hi_nxt = scan_in.hi;
    lo_nxt = scan_in.lo;
    if (in_window && (slot_r > scan_in.hi)) hi_nxt = slot_r;
    if (in_window && (slot_r < scan_in.lo)) lo_nxt = slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= scan_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign scan_out.vld = vld_r;
  assign scan_out.hi  = hi_r;
  assign scan_out.lo  = lo_r;

endmodule

/* rtl/window_range_motion_detector_top.sv */
// Sliding-window motion detector: each accepted reading is written into a
// ring of window_length slots, the largest and smallest stored readings are
// found, and motion is flagged when their spread exceeds motion_threshold
// (a threshold of zero never flags motion). One result item follows every
// input item. The ring is a chain of WINDOW_DEPTH cells, one slot each; a
// max/min token enters the first cell the cycle after the write and moves
// one cell per cycle; the result is offered once the token leaves the last
// cell (a window_length of zero writes nothing, sends no token and reports
// the held flag with motion_changed low). One item is in flight at a time;
// in_stall stays high from accept until the result has been taken. A
// window_length above WINDOW_DEPTH acts as WINDOW_DEPTH. Write the
// configuration registers only while idle.
module window_range_motion_detector_top #(
  parameter int WINDOW_DEPTH = wrmd_pkg::DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [wrmd_pkg::READ_W-1:0]      in_reading,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    out_in_motion,
  output logic                                    out_motion_changed,
  input  logic                                    cfg_we,
  input  logic [wrmd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [wrmd_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import wrmd_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [WLEN_W-1:0]  win_len_r;
  logic [THR_W-1:0]   thr_r;
  logic [SLOT_W-1:0]  wr_slot_r, wr_slot_nxt;
  logic               motion_r;
  logic               start_r;
  logic               out_motion_r;
  logic               out_changed_r;

  logic [LEN_W-1:0]        len_eff;
  logic                    in_acc;
  logic                    out_acc;
  logic [WINDOW_DEPTH-1:0] slot_we;
  logic [WINDOW_DEPTH-1:0] in_win;
  scan_t                   link [0:WINDOW_DEPTH];
  logic signed [READ_W:0]  spread;
  logic                    motion_new;

  // Clamp the window to the physical ring.
  assign len_eff = (32'(win_len_r) > 32'(WINDOW_DEPTH)) ? LEN_W'(WINDOW_DEPTH)
                                                         : LEN_W'(win_len_r);

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Advance the pointer, wrap at the window (also covers a shrunk window).
  assign wr_slot_nxt = ((32'(wr_slot_r) + 32'd1) >= 32'(len_eff)) ? '0
                                                                  : wr_slot_r + 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= WLEN_RESET;
      thr_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_LENGTH:    win_len_r <= cfg_wdata[WLEN_W-1:0];
        CFG_MOTION_THRESHOLD: thr_r     <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = (len_eff == '0) ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        if (link[WINDOW_DEPTH].vld) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: in_stall  = 1'b0;
      ST_SCAN: ;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Write one-hot into the slot the advanced pointer selects.
  always_comb begin
    slot_we = '0;
    if (in_acc && (len_eff != '0)) slot_we[wr_slot_nxt] = 1'b1;
  end

  always_comb begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      in_win[i] = (32'(i) < 32'(len_eff));
    end
  end

  // Seed the token with neutral extremes.
  assign link[0].vld = start_r;
  assign link[0].hi  = READ_MIN;
  assign link[0].lo  = READ_MAX;

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    wrmd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (slot_we[g]),
      .wr_data   (in_reading),
      .in_window (in_win[g]),
      .scan_in   (link[g]),
      .scan_out  (link[g+1])
    );
  end

  // Spread is one bit wider than a reading, so it never overflows.
  assign spread     = {link[WINDOW_DEPTH].hi[READ_W-1], link[WINDOW_DEPTH].hi}
                    - {link[WINDOW_DEPTH].lo[READ_W-1], link[WINDOW_DEPTH].lo};
  assign motion_new = (thr_r != '0) && ($signed({1'b0, spread}) > $signed({2'b00, thr_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r     <= '0;
      motion_r      <= 1'b0;
      start_r       <= 1'b0;
      out_motion_r  <= 1'b0;
      out_changed_r <= 1'b1;
    end else begin
      start_r <= 1'b0;
      if (in_acc) begin
        if (len_eff == '0) begin
          // Frozen window: hold the flag, report no change.
          out_motion_r  <= motion_r;
          out_changed_r <= 1'b0;
        end else begin
          wr_slot_r <= wr_slot_nxt;
          start_r   <= 1'b1;
        end
      end
      if ((state_r == ST_SCAN) && link[WINDOW_DEPTH].vld) begin
        motion_r      <= motion_new;
        out_motion_r  <= motion_new;
        out_changed_r <= (motion_new != motion_r);
      end
    end
  end

  assign out_in_motion      = out_motion_r;
  assign out_motion_changed = out_changed_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after accept");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |=> !out_valid)
    else $error("result offered twice for one item");

  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(slot_we))
    else $error("more than one ring slot written");

  a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    link[WINDOW_DEPTH].vld |-> (state_r == ST_SCAN))
    else $error("scan token arrived outside scan");
`endif

endmodule
